[rtl/page_frame_buffer_engine_defines.svh]
// Assertion macros for the page frame buffer engine.
`ifndef PAGE_FRAME_BUFFER_ENGINE_DEFINES_SVH
`define PAGE_FRAME_BUFFER_ENGINE_DEFINES_SVH

`ifndef SYNTH

`define PFBE_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("page frame buffer engine check failed");

`define PFBE_ASSERT_NXT(name, cond, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("page frame buffer engine check failed");

`else

`define PFBE_ASSERT_IMP(name, cond, prop)

`define PFBE_ASSERT_NXT(name, cond, prop)

`endif

`endif

[rtl/pfbe_pkg.sv]
// Types, codes and helpers for the page frame buffer engine.
package pfbe_pkg;

    localparam int PFBE_PAGE_COUNT   = 8;
    localparam int PFBE_COLUMN_COUNT = 128;

    localparam logic [1:0] FUNC_POINT = 2'd0;
    localparam logic [1:0] FUNC_BLIT  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    localparam logic [1:0] OP_OR   = 2'd0;
    localparam logic [1:0] OP_CLR  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] row;
        logic [6:0] column;
        logic [7:0] width;
        logic [6:0] height;
        logic [7:0] image_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       clipped;
    } t_out;

    // Bits of page pg that lie inside rows [top, bottom).
    function automatic logic [7:0] page_mask(input logic [5:0] top,
                                             input logic [7:0] bottom,
                                             input logic [3:0] pg);
        logic [7:0] base;
        logic [7:0] top_e;
        logic [2:0] lo;
        logic [3:0] hi;
        base  = {1'b0, pg, 3'b000};
        top_e = {2'b00, top};
        lo    = (top_e > base) ? 3'(top_e - base) : 3'd0;
        hi    = (bottom < 8'(base + 8'd8)) ? 4'(bottom - base) : 4'd8;
        return (8'hFF << lo) & (8'hFF >> (4'd8 - hi));
    endfunction

endpackage

[rtl/page_frame_buffer_engine.sv]
// Page frame buffer engine: frame store memory with point, blit, clear and read.
//
// Input channel i_in_valid/o_in_ready carries one command item (t_in); the
// output channel o_out_valid/i_out_ready returns exactly one result (t_out)
// per command, in order. A read returns the stored byte; all other commands
// return zero data. The clipped flag reports dropped writes, empty or cut
// clear rectangles and out-of-range reads.
// The frame store is a single-port-write memory with a registered read; every
// byte touched passes through a read state and then a modify state, which
// writes the byte back (a read only captures it). Point and read touch one
// byte, a blit one or two, a clear every byte in its clipped rectangle; a
// rejected command goes straight to the done state. The engine takes the next
// item once the result has entered the output register.
// After reset the engine zeroes all 2**(PW+CW) memory entries (1024 at the
// default size), one entry per cycle, and holds o_in_ready low.
// When the receiver stalls, the result waits in the output register; a
// finished command then waits until the register frees up.
`include "page_frame_buffer_engine_defines.svh"

module page_frame_buffer_engine #(
    parameter int PAGE_COUNT   = pfbe_pkg::PFBE_PAGE_COUNT,
    parameter int COLUMN_COUNT = pfbe_pkg::PFBE_COLUMN_COUNT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pfbe_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pfbe_pkg::t_out o_out
);
    import pfbe_pkg::*;

    localparam int PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CW    = $clog2(COLUMN_COUNT);
    localparam int AW    = PW + CW;
    localparam int DEPTH = 1 << AW;

    localparam logic [4:0] PC5    = 5'(PAGE_COUNT);
    localparam logic [8:0] CC9    = 9'(COLUMN_COUNT);
    localparam logic [7:0] ROWS8  = 8'(PAGE_COUNT * 8);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_rdata;

    logic [2:0]    r_state;
    logic [AW-1:0] r_init_addr;
    logic [1:0]    r_op;
    logic [3:0]    r_pg;
    logic [3:0]    r_pg_last;
    logic [7:0]    r_col;
    logic [7:0]    r_left;
    logic [8:0]    r_right;
    logic [5:0]    r_top;
    logic [7:0]    r_bottom;
    logic [7:0]    r_bits;
    logic [7:0]    r_hi;
    logic          r_second;
    logic [7:0]    r_data;
    logic          r_clip;
    logic          r_out_valid;
    t_out          r_out;

    // Command decode at acceptance.
    logic [3:0]  in_page;
    logic [2:0]  in_off;
    logic [15:0] in_shift;
    logic        col_oob;
    logic        pg_oob;
    logic        pg1_oob;
    logic [8:0]  x_end;
    logic [7:0]  y_end;
    logic        cut_x;
    logic        cut_y;
    logic [8:0]  clr_right;
    logic [7:0]  clr_bottom;
    logic [7:0]  clr_bot_m1;
    logic        clr_empty;

    always_comb begin
        in_page    = {1'b0, i_in.row[5:3]};
        in_off     = i_in.row[2:0];
        in_shift   = {8'h00, i_in.image_byte} << in_off;
        col_oob    = {2'b00, i_in.column} >= CC9;
        pg_oob     = {1'b0, in_page} >= PC5;
        pg1_oob    = {1'b0, 4'(in_page + 4'd1)} >= PC5;
        x_end      = {2'b00, i_in.column} + {1'b0, i_in.width};
        y_end      = {2'b00, i_in.row} + {1'b0, i_in.height};
        cut_x      = x_end > CC9;
        cut_y      = y_end > ROWS8;
        clr_right  = cut_x ? CC9 : x_end;
        clr_bottom = cut_y ? ROWS8 : y_end;
        clr_bot_m1 = clr_bottom - 8'd1;
        clr_empty  = (i_in.width == 8'd0) || (i_in.height == 7'd0) || col_oob
                     || ({2'b00, i_in.row} >= ROWS8);
    end

    // Memory port control.
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [8:0]    col_next;

    always_comb begin
        col_next = {1'b0, r_col} + 9'd1;
        mem_addr = (r_state == S_INIT) ? r_init_addr : {r_pg[PW-1:0], r_col[CW-1:0]};
        mem_we   = (r_state == S_INIT) || ((r_state == S_MOD) && (r_op != OP_READ));
        case (r_op)
            OP_OR:   mem_wdata = r_rdata | r_bits;
            OP_CLR:  mem_wdata = r_rdata & ~page_mask(r_top, r_bottom, r_pg);
            default: mem_wdata = r_rdata;
        endcase
        if (r_state == S_INIT) begin
            mem_wdata = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_addr <= '0;
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_init_addr <= r_init_addr + 1'b1;
                    if (&r_init_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_data   <= 8'h00;
                        r_clip   <= 1'b0;
                        r_col    <= {1'b0, i_in.column};
                        r_pg     <= in_page;
                        r_hi     <= in_shift[15:8];
                        r_bits   <= in_shift[7:0];
                        r_second <= 1'b0;
                        case (i_in.func)
                            FUNC_POINT: begin
                                r_op   <= OP_OR;
                                r_bits <= 8'h01 << in_off;
                                if (pg_oob || col_oob) begin
                                    r_clip  <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            FUNC_BLIT: begin
                                r_op <= OP_OR;
                                if (col_oob) begin
                                    r_clip  <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_clip <= pg_oob || ((in_off != 3'd0) && pg1_oob);
                                    if (!pg_oob) begin
                                        r_second <= (in_off != 3'd0) && !pg1_oob;
                                        r_state  <= S_RD;
                                    end else if ((in_off != 3'd0) && !pg1_oob) begin
                                        // Only the spill into the next page lands.
                                        r_pg    <= 4'(in_page + 4'd1);
                                        r_bits  <= in_shift[15:8];
                                        r_state <= S_RD;
                                    end else begin
                                        r_state <= S_DONE;
                                    end
                                end
                            end
                            FUNC_CLEAR: begin
                                r_op      <= OP_CLR;
                                r_left    <= {1'b0, i_in.column};
                                r_right   <= clr_right;
                                r_top     <= i_in.row;
                                r_bottom  <= clr_bottom;
                                r_pg_last <= clr_bot_m1[6:3];
                                if (clr_empty) begin
                                    r_clip  <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_clip  <= cut_x || cut_y;
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                r_op <= OP_READ;
                                if (pg_oob || col_oob) begin
                                    r_clip  <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    case (r_op)
                        OP_READ: begin
                            r_data  <= r_rdata;
                            r_state <= S_DONE;
                        end
                        OP_OR: begin
                            if (r_second) begin
                                r_second <= 1'b0;
                                r_pg     <= 4'(r_pg + 4'd1);
                                r_bits   <= r_hi;
                                r_state  <= S_RD;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        default: begin
                            if (col_next < r_right) begin
                                r_col   <= col_next[7:0];
                                r_state <= S_RD;
                            end else if (r_pg < r_pg_last) begin
                                r_pg    <= 4'(r_pg + 4'd1);
                                r_col   <= r_left;
                                r_state <= S_RD;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    endcase
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && (!r_out_valid || i_out_ready)) begin
            r_out.read_data <= r_data;
            r_out.clipped   <= r_clip;
        end
    end

    `PFBE_ASSERT_IMP(a_init_blocks_input, r_state == S_INIT, !o_in_ready)
    `PFBE_ASSERT_IMP(a_write_in_range, (r_state == S_MOD) && mem_we,
        ({1'b0, r_pg} < PC5) && ({1'b0, r_col} < CC9))
    `PFBE_ASSERT_IMP(a_clear_inside_rect, (r_state == S_RD) && (r_op == OP_CLR),
        ({1'b0, r_col} < r_right) && (r_pg <= r_pg_last))
    `PFBE_ASSERT_NXT(a_result_loaded, (r_state == S_DONE) && (!r_out_valid || i_out_ready),
        o_out_valid && (r_state == S_IDLE))

endmodule

[tb/pfbe_scoreboard_pkg.sv]
// Scoreboard for the page frame buffer engine: a shadow frame store and result checks.
package pfbe_scoreboard_pkg;

    import pfbe_pkg::*;

    localparam int FRAME_ROWS = PFBE_PAGE_COUNT * 8;

    class frame_scoreboard;

        bit [7:0] pixels [PFBE_PAGE_COUNT * PFBE_COLUMN_COUNT];
        t_out     expected_results [$];
        int       errors;

        function new();
            foreach (pixels[i]) pixels[i] = 8'h00;
            errors = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // ORs bits into one byte; returns 1 when the byte lies off the store.
        function bit or_bits(int pg, int col, bit [7:0] bits);
            if (pg >= PFBE_PAGE_COUNT || col >= PFBE_COLUMN_COUNT) begin
                return 1'b1;
            end
            pixels[pg * PFBE_COLUMN_COUNT + col] |= bits;
            return 1'b0;
        endfunction

        function bit clear_area(int y, int x, int w, int h);
            bit       cut;
            int       bottom;
            int       right;
            int       base;
            int       lo;
            int       hi;
            bit [7:0] mask;
            cut = 1'b0;
            if (w == 0 || h == 0) begin
                return 1'b1;
            end
            if (x >= PFBE_COLUMN_COUNT || y >= FRAME_ROWS) begin
                return 1'b1;
            end
            if (x + w > PFBE_COLUMN_COUNT) begin
                w   = PFBE_COLUMN_COUNT - x;
                cut = 1'b1;
            end
            if (y + h > FRAME_ROWS) begin
                h   = FRAME_ROWS - y;
                cut = 1'b1;
            end
            bottom = y + h;
            right  = x + w;
            for (int pg = y / 8; pg <= (bottom - 1) / 8; pg++) begin
                base = pg * 8;
                lo   = (y > base) ? y - base : 0;
                hi   = (bottom < base + 8) ? bottom - base : 8;
                mask = (8'hFF << lo) & (8'hFF >> (8 - hi));
                for (int col = x; col < right; col++) begin
                    pixels[pg * PFBE_COLUMN_COUNT + col] &= ~mask;
                end
            end
            return cut;
        endfunction

        function t_out predict_result(t_in c);
            t_out r;
            int   pg;
            int   off;
            int   col;
            pg          = int'(c.row) / 8;
            off         = int'(c.row) % 8;
            col         = int'(c.column);
            r.read_data = 8'h00;
            r.clipped   = 1'b0;
            case (c.func)
                FUNC_POINT: begin
                    r.clipped = or_bits(pg, col, 8'h01 << off);
                end
                FUNC_BLIT: begin
                    if (col >= PFBE_COLUMN_COUNT) begin
                        r.clipped = 1'b1;
                    end else begin
                        if (or_bits(pg, col, c.image_byte << off)) r.clipped = 1'b1;
                        // The high bits spill into the next page down.
                        if (off != 0 && or_bits(pg + 1, col, c.image_byte >> (8 - off)))
                            r.clipped = 1'b1;
                    end
                end
                FUNC_CLEAR: begin
                    r.clipped = clear_area(int'(c.row), col, int'(c.width),
                                           int'(c.height));
                end
                default: begin
                    if (pg >= PFBE_PAGE_COUNT || col >= PFBE_COLUMN_COUNT) begin
                        r.clipped = 1'b1;
                    end else begin
                        r.read_data = pixels[pg * PFBE_COLUMN_COUNT + col];
                    end
                end
            endcase
            return r;
        endfunction

        function void note_command(t_in c);
            expected_results.push_back(predict_result(c));
        endfunction

        function void check_result(t_out got);
            t_out exp_r;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual data %02h clipped %0b",
                         $time, got.read_data, got.clipped);
                errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (got.read_data !== exp_r.read_data) begin
                $display("%0t: read_data mismatch, expected %02h, actual %02h",
                         $time, exp_r.read_data, got.read_data);
                errors++;
            end
            if (got.clipped !== exp_r.clipped) begin
                $display("%0t: clipped mismatch, expected %0b, actual %0b",
                         $time, exp_r.clipped, got.clipped);
                errors++;
            end
        endfunction

    endclass

endpackage

[tb/page_frame_buffer_engine_tb.sv]
// Testbench for the page frame buffer engine: directed and random commands, checked in order.
module page_frame_buffer_engine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pfbe_pkg::*;
    import pfbe_scoreboard_pkg::*;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_item  = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_item;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int rx_hold_cycles = 0;

    frame_scoreboard sb = new();

    page_frame_buffer_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Covers every item being a full-screen clear, with room to spare.
    initial begin
        #(100_000_000);
        $display("status: fail");
        $finish;
    end

    // Result side: checks every accepted item and stalls at random or on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (out_valid && out_ready) sb.check_result(out_item);
            if (rx_hold_cycles > 0) begin
                out_ready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    function automatic t_in make_cmd(logic [1:0] func, int row, int col, int w, int h,
                                     int img);
        t_in c;
        c.func       = func;
        c.row        = 6'(row);
        c.column     = 7'(col);
        c.width      = 8'(w);
        c.height     = 7'(h);
        c.image_byte = 8'(img);
        return c;
    endfunction

    function automatic t_in random_command(int hot_col);
        t_in c;
        int  pick;
        c.row        = 6'($urandom_range(0, 63));
        c.width      = 8'($urandom_range(0, 255));
        c.height     = 7'($urandom_range(0, 127));
        c.image_byte = 8'($urandom());
        // Most items land in a narrow band of columns so that reads see earlier writes.
        if ($urandom_range(0, 4) != 0)
            c.column = 7'((hot_col + $urandom_range(0, 7)) % PFBE_COLUMN_COUNT);
        else
            c.column = 7'($urandom_range(0, 127));
        pick = $urandom_range(0, 99);
        if (pick < 22)      c.func = FUNC_POINT;
        else if (pick < 47) c.func = FUNC_BLIT;
        else if (pick < 62) c.func = FUNC_CLEAR;
        else                c.func = FUNC_READ;
        if (c.func == FUNC_CLEAR) begin
            pick = $urandom_range(0, 39);
            if (pick == 0) begin
                // Occasional unrestricted rectangle, which may be large.
            end else if (pick < 10) begin
                // Overhang at the right or bottom edge, cheap after clipping.
                c.column = 7'(PFBE_COLUMN_COUNT - $urandom_range(1, 8));
                c.row    = 6'(FRAME_ROWS - $urandom_range(1, 16));
            end else begin
                c.width  = 8'($urandom_range(0, 12));
                c.height = 7'($urandom_range(0, 20));
            end
        end
        return c;
    endfunction

    task automatic send_cmd(t_in c);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= c;
        do @(posedge i_clk); while (!in_ready);
        sb.note_command(c);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
    endtask

    initial begin
        int hot_col;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every operation and the clipping cases.
        send_cmd(make_cmd(FUNC_READ,   0,   0,   0,   0,   0));
        send_cmd(make_cmd(FUNC_POINT,  0,   0, 255, 127,   0));
        send_cmd(make_cmd(FUNC_POINT, 63, 127,   0,   0, 255));
        send_cmd(make_cmd(FUNC_READ,   0,   0,   0,   0,   0));
        send_cmd(make_cmd(FUNC_READ,  63, 127,   0,   0,   0));
        send_cmd(make_cmd(FUNC_BLIT,   0,   5,   0,   0, 255));
        send_cmd(make_cmd(FUNC_BLIT,  13,   5,   0,   0, 165));
        send_cmd(make_cmd(FUNC_BLIT,  60,   6,   0,   0, 255));
        send_cmd(make_cmd(FUNC_BLIT,   7, 127,   0,   0, 255));
        send_cmd(make_cmd(FUNC_READ,   8,   5,   0,   0,   0));
        send_cmd(make_cmd(FUNC_READ,  16,   5,   0,   0,   0));
        send_cmd(make_cmd(FUNC_READ,  56,   6,   0,   0,   0));
        send_cmd(make_cmd(FUNC_READ,   8, 127,   0,   0,   0));
        send_cmd(make_cmd(FUNC_CLEAR,  0,   0,   0,  64,   0));
        send_cmd(make_cmd(FUNC_CLEAR,  0,   0, 128,   0,   0));
        send_cmd(make_cmd(FUNC_CLEAR, 60, 120, 255, 127,   0));
        send_cmd(make_cmd(FUNC_CLEAR,  3,   4,   4,  10,   0));
        send_cmd(make_cmd(FUNC_READ,   0,   5,   0,   0,   0));
        send_cmd(make_cmd(FUNC_READ,  12,   5,   0,   0,   0));
        send_cmd(make_cmd(FUNC_CLEAR,  0,   0, 128,  64,   0));
        send_cmd(make_cmd(FUNC_READ,  16,   5,   0,   0,   0));
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
                default: begin src_idle_pct = 29; sink_stall_pct = 29; end
            endcase
            hot_col = $urandom_range(0, 127);
            // Long receiver hold-off while items keep coming, so the input backs up.
            if (phase == 0) rx_hold_cycles = 600;
            for (int n = 0; n < 275; n++) begin
                if (phase == 1 && n == 137) wait_drained();
                if (n % 60 == 59) hot_col = $urandom_range(0, 127);
                send_cmd(random_command(hot_col));
            end
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/pfbe_pkg.sv
rtl/page_frame_buffer_engine.sv
tb/pfbe_scoreboard_pkg.sv
tb/page_frame_buffer_engine_tb.sv
